/* src/qru_pkg.sv */
// Shared types, constants and the saturation helper for the quaternion rotate unit.
// Used by the channel interfaces, the product pipeline and the top level.
// Depends on nothing.
package qru_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_PRODUCT = 2'd0;
    localparam logic [1:0] FUNC_ROTATE  = 2'd1;
    localparam logic [1:0] FUNC_CONJ    = 2'd2;

    // Q15.16 component, operand widened for exact negation, and derived widths.
    localparam int COMP_W  = 32;
    localparam int OPND_W  = COMP_W + 1;
    localparam int PROD_W  = OPND_W + COMP_W;
    localparam int FRAC_W  = 16;
    localparam int SH_W    = PROD_W - FRAC_W;
    localparam int SUM_W   = SH_W + 2;
    localparam int NCOMP   = 4;

    typedef logic [1:0]               func_t;
    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SH_W-1:0]   sh_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Saturated component together with its overflow flag.
    typedef struct packed {
        logic [COMP_W-1:0] val;
        logic              ov;
    } sat_t;

    // Clamp a wide signed sum into the 32-bit component range.
    function automatic sat_t sat_comp(input sum_t v);
        sat_t s;
        if ((v[SUM_W-1:COMP_W-1] == {(SUM_W-COMP_W+1){1'b0}}) ||
            (v[SUM_W-1:COMP_W-1] == {(SUM_W-COMP_W+1){1'b1}}))
        begin
            s.val = v[COMP_W-1:0];
            s.ov  = 1'b0;
        end
        else if (v[SUM_W-1])
        begin
            s.val = {1'b1, {(COMP_W-1){1'b0}}};
            s.ov  = 1'b1;
        end
        else
        begin
            s.val = {1'b0, {(COMP_W-1){1'b1}}};
            s.ov  = 1'b1;
        end
        return s;
    endfunction

endpackage

/* src/qru_op_if.sv */
// Operation channel of the quaternion rotate unit: valid, ready and one operand pair.
// Depends on qru_pkg.
interface qru_op_if;
    logic               valid;
    logic               ready;
    qru_pkg::func_t     func;
    qru_pkg::comp_t     a_x;
    qru_pkg::comp_t     a_y;
    qru_pkg::comp_t     a_z;
    qru_pkg::comp_t     a_w;
    qru_pkg::comp_t     b_x;
    qru_pkg::comp_t     b_y;
    qru_pkg::comp_t     b_z;
    qru_pkg::comp_t     b_w;

    modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    input ready);
    modport sink   (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    output ready);
endinterface

/* src/qru_res_if.sv */
// Result channel of the quaternion rotate unit: valid, ready and one result quaternion.
// Depends on qru_pkg.
interface qru_res_if;
    logic               valid;
    logic               ready;
    qru_pkg::comp_t     r_x;
    qru_pkg::comp_t     r_y;
    qru_pkg::comp_t     r_z;
    qru_pkg::comp_t     r_w;
    logic               overflow;

    modport source (output valid, r_x, r_y, r_z, r_w, overflow, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_w, overflow, output ready);
endinterface

/* src/quaternion_rotate_unit.sv */
// Top level of the quaternion rotate unit: input register, two product pipelines, result register.
// Depends on qru_pkg, qru_op_if, qru_res_if and qru_qmul.
//
//   Channel  Dir  Beat contents
//   op       in   func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
//   res      out  r_x, r_y, r_z, r_w, overflow
//
// One beat is accepted per cycle unless a stall on res holds the pipeline; every beat gives one result beat.
// On its way a beat passes the input register, two three-stage product pipelines
// (multiply, sum, saturate) and the result register.
// Reset clears only the valid bits; no state survives between beats.
// The whole pipeline advances when the result register is empty or being taken,
// so a stall on res freezes every stage and nothing is lost or repeated.
module quaternion_rotate_unit (
    input  logic       clk,
    input  logic       rst_n,
    qru_op_if.sink     op,
    qru_res_if.source  res
);

    localparam int DEPTH = 7;
    localparam int SIDE  = 3;

    logic           adv;
    logic [DEPTH-1:0] valid_reg;
    logic           out_valid_reg;

    // Stage 0: input register.
    qru_pkg::func_t func0_reg;
    qru_pkg::comp_t a0_reg [qru_pkg::NCOMP];
    qru_pkg::comp_t b0_reg [qru_pkg::NCOMP];

    // Side data beside the first product pipeline.
    qru_pkg::func_t func1_reg [SIDE];
    qru_pkg::comp_t b1_reg    [SIDE][qru_pkg::NCOMP];

    // Early result beside the second product pipeline.
    qru_pkg::func_t func2_reg [SIDE];
    qru_pkg::comp_t e_reg     [SIDE][qru_pkg::NCOMP];
    logic           eov_reg   [SIDE];

    qru_pkg::opnd_t p1 [qru_pkg::NCOMP];
    qru_pkg::comp_t t  [qru_pkg::NCOMP];
    logic           t_sat [qru_pkg::NCOMP];
    qru_pkg::opnd_t p2 [qru_pkg::NCOMP];
    qru_pkg::comp_t full [qru_pkg::NCOMP];
    logic           full_sat [qru_pkg::NCOMP];

    qru_pkg::opnd_t neg_b [qru_pkg::NCOMP];
    qru_pkg::sat_t  conj  [qru_pkg::NCOMP];
    qru_pkg::comp_t e_next [qru_pkg::NCOMP];
    logic           eov_next;

    qru_pkg::comp_t r_reg  [qru_pkg::NCOMP];
    qru_pkg::comp_t r_next [qru_pkg::NCOMP];
    logic           ov_reg;
    logic           ov_next;

    // Global advance: the result register is free or being emptied.
    assign adv      = !out_valid_reg || res.ready;
    assign op.ready = adv;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[DEPTH-2:0], op.valid};
            out_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func0_reg <= op.func;
            a0_reg[0] <= op.a_x;
            a0_reg[1] <= op.a_y;
            a0_reg[2] <= op.a_z;
            a0_reg[3] <= op.a_w;
            b0_reg[0] <= op.b_x;
            b0_reg[1] <= op.b_y;
            b0_reg[2] <= op.b_z;
            b0_reg[3] <= op.b_w;
        end
    end

    // First product operand: in rotate mode the scalar part of a is dropped.
    always_comb
    begin
        for (int i = 0; i < qru_pkg::NCOMP - 1; i++)
        begin
            p1[i] = qru_pkg::opnd_t'(a0_reg[i]);
        end
        p1[3] = (func0_reg == qru_pkg::FUNC_ROTATE) ? '0 : qru_pkg::opnd_t'(a0_reg[3]);
    end

    qru_qmul u_qmul_first (
        .clk (clk),
        .en  (adv),
        .p   (p1),
        .q   (b0_reg),
        .r   (t),
        .sat (t_sat)
    );

    // Carry func and b alongside the first pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func1_reg[0] <= func0_reg;
            b1_reg[0]    <= b0_reg;
            for (int s = 1; s < SIDE; s++)
            begin
                func1_reg[s] <= func1_reg[s-1];
                b1_reg[s]    <= b1_reg[s-1];
            end
        end
    end

    // Conjugate of b, negated at 33 bits so it is exact before the final clamp.
    always_comb
    begin
        for (int i = 0; i < qru_pkg::NCOMP - 1; i++)
        begin
            neg_b[i] = -qru_pkg::opnd_t'(b1_reg[SIDE-1][i]);
            conj[i]  = qru_pkg::sat_comp(qru_pkg::sum_t'(neg_b[i]));
        end
        neg_b[3] = qru_pkg::opnd_t'(b1_reg[SIDE-1][3]);
        conj[3]  = qru_pkg::sat_comp(qru_pkg::sum_t'(neg_b[3]));
    end

    // Second product operands: conj(b) times the intermediate t.
    assign p2 = neg_b;

    qru_qmul u_qmul_second (
        .clk (clk),
        .en  (adv),
        .p   (p2),
        .q   (t),
        .r   (full),
        .sat (full_sat)
    );

    // Early result for every mode but rotate, and the intermediate overflow for rotate.
    always_comb
    begin
        case (func1_reg[SIDE-1])
            qru_pkg::FUNC_PRODUCT:
            begin
                e_next   = t;
                eov_next = t_sat[0] | t_sat[1] | t_sat[2] | t_sat[3];
            end
            qru_pkg::FUNC_ROTATE:
            begin
                e_next   = '{default: '0};
                eov_next = t_sat[0] | t_sat[1] | t_sat[2] | t_sat[3];
            end
            qru_pkg::FUNC_CONJ:
            begin
                for (int i = 0; i < qru_pkg::NCOMP; i++)
                begin
                    e_next[i] = conj[i].val;
                end
                eov_next = conj[0].ov | conj[1].ov | conj[2].ov;
            end
            default:
            begin
                e_next   = '{default: '0};
                eov_next = 1'b0;
            end
        endcase
    end

    // Carry the early result alongside the second pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func2_reg[0] <= func1_reg[SIDE-1];
            e_reg[0]     <= e_next;
            eov_reg[0]   <= eov_next;
            for (int s = 1; s < SIDE; s++)
            begin
                func2_reg[s] <= func2_reg[s-1];
                e_reg[s]     <= e_reg[s-1];
                eov_reg[s]   <= eov_reg[s-1];
            end
        end
    end

    // Final selection; the scalar part of the rotation result is set to zero.
    always_comb
    begin
        if (func2_reg[SIDE-1] == qru_pkg::FUNC_ROTATE)
        begin
            r_next[0] = full[0];
            r_next[1] = full[1];
            r_next[2] = full[2];
            r_next[3] = '0;
            ov_next   = eov_reg[SIDE-1] | full_sat[0] | full_sat[1] | full_sat[2];
        end
        else
        begin
            r_next  = e_reg[SIDE-1];
            ov_next = eov_reg[SIDE-1];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg  <= r_next;
            ov_reg <= ov_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.r_x      = r_reg[0];
    assign res.r_y      = r_reg[1];
    assign res.r_z      = r_reg[2];
    assign res.r_w      = r_reg[3];
    assign res.overflow = ov_reg;

endmodule

/* src/qru_qmul.sv */
// Three-stage Hamilton product p*q in Q15.16 with per-component saturation.
// Stage 1 multiplies, stage 2 shifts and sums, stage 3 saturates.
// Depends on qru_pkg.
module qru_qmul (
    input  logic            clk,
    input  logic            en,
    input  qru_pkg::opnd_t  p [qru_pkg::NCOMP],
    input  qru_pkg::comp_t  q [qru_pkg::NCOMP],
    output qru_pkg::comp_t  r [qru_pkg::NCOMP],
    output logic            sat [qru_pkg::NCOMP]
);

    qru_pkg::prod_t prod_reg [qru_pkg::NCOMP][qru_pkg::NCOMP];
    qru_pkg::sh_t   sh       [qru_pkg::NCOMP][qru_pkg::NCOMP];
    qru_pkg::sum_t  sum_reg  [qru_pkg::NCOMP];
    qru_pkg::sum_t  sum_next [qru_pkg::NCOMP];
    qru_pkg::comp_t res_reg  [qru_pkg::NCOMP];
    logic           sat_reg  [qru_pkg::NCOMP];
    qru_pkg::sat_t  clamp    [qru_pkg::NCOMP];

    // Stage 1: all sixteen cross products, formed exactly.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < qru_pkg::NCOMP; i++)
            begin
                for (int j = 0; j < qru_pkg::NCOMP; j++)
                begin
                    prod_reg[i][j] <= p[i] * q[j];
                end
            end
        end
    end

    // Arithmetic shift right by the fraction width, which floors.
    always_comb
    begin
        for (int i = 0; i < qru_pkg::NCOMP; i++)
        begin
            for (int j = 0; j < qru_pkg::NCOMP; j++)
            begin
                sh[i][j] = prod_reg[i][j][qru_pkg::PROD_W-1:qru_pkg::FRAC_W];
            end
        end
    end

    // Hamilton sums, components ordered x, y, z, w.
    always_comb
    begin
        sum_next[0] = qru_pkg::sum_t'(sh[3][0]) + qru_pkg::sum_t'(sh[0][3])
                    + qru_pkg::sum_t'(sh[1][2]) - qru_pkg::sum_t'(sh[2][1]);
        sum_next[1] = qru_pkg::sum_t'(sh[3][1]) + qru_pkg::sum_t'(sh[1][3])
                    + qru_pkg::sum_t'(sh[2][0]) - qru_pkg::sum_t'(sh[0][2]);
        sum_next[2] = qru_pkg::sum_t'(sh[3][2]) + qru_pkg::sum_t'(sh[2][3])
                    + qru_pkg::sum_t'(sh[0][1]) - qru_pkg::sum_t'(sh[1][0]);
        sum_next[3] = qru_pkg::sum_t'(sh[3][3]) - qru_pkg::sum_t'(sh[0][0])
                    - qru_pkg::sum_t'(sh[1][1]) - qru_pkg::sum_t'(sh[2][2]);
    end

    // Stage 2: sums.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < qru_pkg::NCOMP; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    // Saturation to the component range.
    always_comb
    begin
        for (int i = 0; i < qru_pkg::NCOMP; i++)
        begin
            clamp[i] = qru_pkg::sat_comp(sum_reg[i]);
        end
    end

    // Stage 3: saturated components and their flags.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < qru_pkg::NCOMP; i++)
            begin
                res_reg[i] <= clamp[i].val;
                sat_reg[i] <= clamp[i].ov;
            end
        end
    end

    assign r   = res_reg;
    assign sat = sat_reg;

endmodule
